>>> rtl/rfb_pkg.sv
// Shared types and constants for the RHF Fock matrix build core.
package rfb_pkg;

   localparam int VALUE_W = 32;
   localparam int IDX_IN_W = 4;
   localparam int CSR_W = 5;
   localparam int FRAC_W = 24;
   localparam logic [CSR_W-1:0] ORB_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_LOAD_CORE = 2'd0,
      OP_LOAD_DENSITY = 2'd1,
      OP_LOAD_INTEGRAL = 2'd2,
      OP_COMPUTE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_ROUND,
      ST_EMIT
   } state_type;

endpackage

>>> rtl/rfb_if.sv
// Channel interfaces: request, response and configuration write.
interface rfb_req_if;
   logic valid;
   logic ready;
   rfb_pkg::op_type operation;
   logic [rfb_pkg::IDX_IN_W-1:0] index_a;
   logic [rfb_pkg::IDX_IN_W-1:0] index_b;
   logic [rfb_pkg::IDX_IN_W-1:0] index_c;
   logic [rfb_pkg::IDX_IN_W-1:0] index_d;
   logic signed [rfb_pkg::VALUE_W-1:0] load_value;

   modport source (output valid, operation, index_a, index_b, index_c, index_d, load_value,
                   input ready);
   modport sink (input valid, operation, index_a, index_b, index_c, index_d, load_value,
                 output ready);
endinterface

interface rfb_rsp_if;
   logic valid;
   logic ready;
   logic [rfb_pkg::IDX_IN_W-1:0] fock_row;
   logic [rfb_pkg::IDX_IN_W-1:0] fock_col;
   logic signed [rfb_pkg::VALUE_W-1:0] fock_value;
   logic saturated;

   modport source (output valid, fock_row, fock_col, fock_value, saturated, input ready);
   modport sink (input valid, fock_row, fock_col, fock_value, saturated, output ready);
endinterface

interface rfb_csr_if;
   logic valid;
   logic ready;
   logic [rfb_pkg::CSR_W-1:0] orbitals_in_use;

   modport source (output valid, orbitals_in_use, input ready);
   modport sink (input valid, orbitals_in_use, output ready);
endinterface

>>> rtl/rhf_fock_matrix_build_core.sv
// RHF Fock element builder: operand stores, sequencer and shared multiply-accumulate unit.
//
//  channel   dir   handshake       carries
//  req_bus   in    valid/ready     operation, index_a..index_d, load_value
//  rsp_bus   out   valid/ready     fock_row, fock_col, fock_value, saturated
//  csr_bus   in    valid/ready     orbitals_in_use (K)
//
// During a compute transaction the MAC unit consumes one density element and two integrals
// per cycle from the store read ports.
// Reset clears control state and sets K to 16; the stores are not cleared.
// Loads are taken while a result waits on rsp_bus; a finished compute holds in its
// last step until the response register is free.
module rhf_fock_matrix_build_core #(
   parameter int MAX_ORBITALS = 16
) (
   input logic clock,
   input logic reset,
   rfb_req_if.sink req_bus,
   rfb_rsp_if.source rsp_bus,
   rfb_csr_if.sink csr_bus
);

   localparam int IDX_W = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
   localparam int SQ_N = MAX_ORBITALS * MAX_ORBITALS;
   localparam int QUAD_N = SQ_N * SQ_N;
   localparam int SQ_W = (SQ_N > 1) ? $clog2(SQ_N) : 1;
   localparam int QUAD_W = (QUAD_N > 1) ? $clog2(QUAD_N) : 1;
   localparam int KW = $clog2(MAX_ORBITALS + 1);
   localparam int CW = KW + 1;
   localparam int VW = rfb_pkg::VALUE_W;
   localparam int PW = 2 * VW;
   localparam int ACC_W = PW + 4 + $clog2(SQ_N + 1);
   localparam int SHIFT = rfb_pkg::FRAC_W + 1;
   localparam int RW = ACC_W - SHIFT;
   localparam int CSR_W = rfb_pkg::CSR_W;
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      {{(ACC_W - rfb_pkg::FRAC_W - 1){1'b0}}, 1'b1, {rfb_pkg::FRAC_W{1'b0}}};

   function automatic logic [SQ_W-1:0] sq_addr(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
      return SQ_W'(r) * SQ_W'(MAX_ORBITALS) + SQ_W'(c);
   endfunction

   function automatic logic [QUAD_W-1:0] quad_addr(input logic [IDX_W-1:0] i0,
                                                   input logic [IDX_W-1:0] i1,
                                                   input logic [IDX_W-1:0] i2,
                                                   input logic [IDX_W-1:0] i3);
      logic [QUAD_W-1:0] m;
      m = QUAD_W'(MAX_ORBITALS);
      return ((QUAD_W'(i0) * m + QUAD_W'(i1)) * m + QUAD_W'(i2)) * m + QUAD_W'(i3);
   endfunction

   // index reduction modulo MAX_ORBITALS
   logic [IDX_W-1:0] red_lut [16];
   for (genvar i = 0; i < 16; i++) begin : g_red
      assign red_lut[i] = IDX_W'(i % MAX_ORBITALS);
   end

   rfb_pkg::state_type state_ff, state_in;

   logic [CSR_W-1:0] orb_ff;
   logic [KW-1:0] k_ff, k_in;
   logic [IDX_W-1:0] mu_ff, nu_ff, x_ff, y_ff, x_in, y_in;
   logic [IDX_W-1:0] a_red, b_red, c_red, d_red;

   logic signed [VW-1:0] core_mem [SQ_N];
   logic signed [VW-1:0] dens_mem [SQ_N];
   logic signed [VW-1:0] int_mem [QUAD_N];
   logic signed [VW-1:0] core_ff, d_ff, g1_ff, g2_ff;

   logic rd_v_ff, mul_v_ff, diff_v_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic signed [ACC_W-1:0] diff_ff, acc_ff, sum_ff;

   logic rsp_valid_ff;
   logic [rfb_pkg::IDX_IN_W-1:0] row_ff, col_ff;
   logic signed [VW-1:0] val_ff;
   logic sat_ff;

   logic req_ready, accept, start, run_en, last_pair, emit_load, pipe_empty;
   logic signed [RW-1:0] res_wide;
   logic res_sat;
   logic signed [VW-1:0] res_val;

   assign a_red = red_lut[req_bus.index_a];
   assign b_red = red_lut[req_bus.index_b];
   assign c_red = red_lut[req_bus.index_c];
   assign d_red = red_lut[req_bus.index_d];

   assign accept = req_bus.valid && req_ready;
   assign start = accept && (req_bus.operation == rfb_pkg::OP_COMPUTE);
   assign last_pair = ((CW'(x_ff) + CW'(1)) == CW'(k_ff)) &&
                      ((CW'(y_ff) + CW'(1)) == CW'(k_ff));
   assign pipe_empty = !rd_v_ff && !mul_v_ff && !diff_v_ff;

   always_comb begin
      if ({1'b0, orb_ff} > (CSR_W + 1)'(MAX_ORBITALS)) begin
         k_in = KW'(MAX_ORBITALS);
      end else begin
         k_in = KW'(orb_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rfb_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (k_in == '0) ? rfb_pkg::ST_DRAIN : rfb_pkg::ST_RUN;
            end
         end
         rfb_pkg::ST_RUN: begin
            if (last_pair) begin
               state_in = rfb_pkg::ST_DRAIN;
            end
         end
         rfb_pkg::ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = rfb_pkg::ST_ROUND;
            end
         end
         rfb_pkg::ST_ROUND: state_in = rfb_pkg::ST_EMIT;
         rfb_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = rfb_pkg::ST_IDLE;
            end
         end
         default: state_in = rfb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      run_en = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         rfb_pkg::ST_IDLE: req_ready = 1'b1;
         rfb_pkg::ST_RUN: run_en = 1'b1;
         rfb_pkg::ST_EMIT: emit_load = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if ((CW'(y_ff) + CW'(1)) == CW'(k_ff)) begin
         y_in = '0;
         x_in = x_ff + IDX_W'(1);
      end else begin
         y_in = y_ff + IDX_W'(1);
      end
   end

   assign res_wide = RW'(sum_ff >>> SHIFT);
   assign res_sat = (res_wide[RW-1:VW-1] != '0) && (res_wide[RW-1:VW-1] != '1);
   always_comb begin
      if (!res_sat) begin
         res_val = res_wide[VW-1:0];
      end else if (res_wide[RW-1]) begin
         res_val = {1'b1, {(VW-1){1'b0}}};
      end else begin
         res_val = {1'b0, {(VW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfb_pkg::ST_IDLE;
         orb_ff <= rfb_pkg::ORB_RESET;
         rd_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
         diff_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid) begin
            orb_ff <= csr_bus.orbitals_in_use;
         end
         rd_v_ff <= run_en;
         mul_v_ff <= rd_v_ff;
         diff_v_ff <= mul_v_ff;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mu_ff <= a_red;
         nu_ff <= b_red;
         k_ff <= k_in;
         x_ff <= '0;
         y_ff <= '0;
      end else if (run_en) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      p1_ff <= d_ff * g1_ff;
      p2_ff <= d_ff * g2_ff;
      diff_ff <= (ACC_W'(p1_ff) <<< 1) - ACC_W'(p2_ff);
      if (start) begin
         acc_ff <= '0;
      end else if (diff_v_ff) begin
         acc_ff <= acc_ff + diff_ff;
      end
      sum_ff <= acc_ff + ((ACC_W'(core_ff) <<< SHIFT) | ROUND_HALF);
      if (emit_load) begin
         row_ff <= rfb_pkg::IDX_IN_W'(mu_ff);
         col_ff <= rfb_pkg::IDX_IN_W'(nu_ff);
         val_ff <= res_val;
         sat_ff <= res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_bus.operation == rfb_pkg::OP_LOAD_CORE)) begin
         core_mem[sq_addr(a_red, b_red)] <= req_bus.load_value;
      end
      if (start) begin
         core_ff <= core_mem[sq_addr(a_red, b_red)];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_bus.operation == rfb_pkg::OP_LOAD_DENSITY)) begin
         dens_mem[sq_addr(a_red, b_red)] <= req_bus.load_value;
      end
      d_ff <= dens_mem[sq_addr(x_ff, y_ff)];
   end

   always_ff @(posedge clock) begin
      if (accept && (req_bus.operation == rfb_pkg::OP_LOAD_INTEGRAL)) begin
         int_mem[quad_addr(a_red, b_red, c_red, d_red)] <= req_bus.load_value;
      end
      g1_ff <= int_mem[quad_addr(mu_ff, nu_ff, y_ff, x_ff)];
      g2_ff <= int_mem[quad_addr(mu_ff, x_ff, y_ff, nu_ff)];
   end

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.fock_row = row_ff;
   assign rsp_bus.fock_col = col_ff;
   assign rsp_bus.fock_value = val_ff;
   assign rsp_bus.saturated = sat_ff;

endmodule
